FILE: hw/rtl/bpi_pkg.sv
// Shared constants for the bilinear patch interpolator.
package bpi_pkg;

    localparam int BPI_COORD_BITS = 16;
    localparam int IDX_BITS       = 13;
    localparam int Q_SHIFT        = 12;
    localparam int Q_ONE          = 1 << Q_SHIFT;
    // weight = Q_ONE - index * floor(Q_ONE / steps), index and quotient below 2**IDX_BITS
    localparam int W_BITS         = 2 * IDX_BITS + 1;
    localparam int RECIP_STAGES   = 4;
    localparam int RECIP_BITS_PER = (IDX_BITS + RECIP_STAGES - 1) / RECIP_STAGES;
    localparam int LERP_STAGES    = 3;
    // reciprocal, weight, outer linear step, inner linear step
    localparam int PIPE_STAGES    = RECIP_STAGES + 1 + 2 * LERP_STAGES;

endpackage

FILE: hw/rtl/bpi_recip.sv
// Pipelined restoring divider forming floor(Q_ONE / steps).
module bpi_recip
    import bpi_pkg::*;
(
    input  logic                    clk,
    input  logic [RECIP_STAGES-1:0] en,
    input  logic [IDX_BITS-1:0]     steps,
    output logic [IDX_BITS-1:0]     quo
);

    logic [IDX_BITS-1:0] rem_reg [RECIP_STAGES];
    logic [IDX_BITS-1:0] quo_reg [RECIP_STAGES];
    logic [IDX_BITS-1:0] den_reg [RECIP_STAGES];

    genvar s;
    generate
        for (s = 0; s < RECIP_STAGES; s++)
        begin : g_stage
            localparam int HI = IDX_BITS - 1 - s * RECIP_BITS_PER;
            localparam int NB = (HI + 1 < RECIP_BITS_PER) ? HI + 1 : RECIP_BITS_PER;

            logic [IDX_BITS-1:0] rem_in;
            logic [IDX_BITS-1:0] quo_in;
            logic [IDX_BITS-1:0] den_in;
            logic [IDX_BITS-1:0] rem_next;
            logic [IDX_BITS-1:0] quo_next;

            if (s == 0)
            begin : g_first
                assign rem_in = '0;
                assign quo_in = '0;
                assign den_in = steps;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[s-1];
                assign quo_in = quo_reg[s-1];
                assign den_in = den_reg[s-1];
            end

            // one quotient bit per step, dividend has only bit Q_SHIFT set
            always_comb
            begin
                logic [IDX_BITS:0]   trial;
                logic [IDX_BITS-1:0] r;
                logic [IDX_BITS-1:0] q;
                r = rem_in;
                q = quo_in;
                for (int j = 0; j < NB; j++)
                begin
                    trial = {r, ((HI - j) == Q_SHIFT)};
                    if (trial >= {1'b0, den_in})
                    begin
                        trial = trial - {1'b0, den_in};
                        q     = {q[IDX_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        q     = {q[IDX_BITS-2:0], 1'b0};
                    end
                    r = trial[IDX_BITS-1:0];
                end
                rem_next = r;
                quo_next = q;
            end

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    rem_reg[s] <= rem_next;
                    quo_reg[s] <= quo_next;
                    den_reg[s] <= den_in;
                end
            end
        end
    endgenerate

    assign quo = quo_reg[RECIP_STAGES-1];

endmodule

FILE: hw/rtl/bpi_lerp.sv
// Three-stage linear step: saturated difference, weight product, floor and saturate.
module bpi_lerp
    import bpi_pkg::*;
#(
    parameter int COORD_BITS = BPI_COORD_BITS
)
(
    input  logic                         clk,
    input  logic [LERP_STAGES-1:0]       en,
    input  logic signed [COORD_BITS-1:0] start_value,
    input  logic signed [COORD_BITS-1:0] end_value,
    input  logic signed [W_BITS-1:0]     weight,
    input  logic                         zero_steps,
    output logic signed [COORD_BITS-1:0] result
);

    localparam int PB = W_BITS + COORD_BITS;
    localparam int SB = PB + 1;

    // stage A
    logic signed [COORD_BITS-1:0] start_a_reg;
    logic signed [COORD_BITS-1:0] end_a_reg;
    logic signed [W_BITS-1:0]     weight_a_reg;
    logic                         zero_a_reg;
    logic signed [COORD_BITS-1:0] diff_a_reg;
    logic signed [COORD_BITS-1:0] diff_a_next;
    logic signed [COORD_BITS:0]   diff_full;

    // stage B
    logic signed [COORD_BITS-1:0] start_b_reg;
    logic signed [COORD_BITS-1:0] end_b_reg;
    logic                         zero_b_reg;
    logic signed [PB-1:0]         prod_b_reg;
    logic signed [PB-1:0]         prod_b_next;

    // stage C
    logic signed [COORD_BITS-1:0] res_c_reg;
    logic signed [COORD_BITS-1:0] res_c_next;
    logic signed [SB-1:0]         sum_full;
    logic [SB-Q_SHIFT-1:0]        floored;
    logic [SB-Q_SHIFT-COORD_BITS:0] upper;

    assign diff_full = (COORD_BITS+1)'(start_value) - (COORD_BITS+1)'(end_value);

    always_comb
    begin
        if (diff_full[COORD_BITS] != diff_full[COORD_BITS-1])
            diff_a_next = {diff_full[COORD_BITS], {(COORD_BITS-1){~diff_full[COORD_BITS]}}};
        else
            diff_a_next = diff_full[COORD_BITS-1:0];
    end

    assign prod_b_next = weight_a_reg * diff_a_reg;

    // end * Q_ONE + w * d, then floor by arithmetic shift
    assign sum_full = (SB'(end_b_reg) <<< Q_SHIFT) + SB'(prod_b_reg);
    assign floored  = sum_full[SB-1:Q_SHIFT];
    assign upper    = floored[SB-Q_SHIFT-1:COORD_BITS-1];

    always_comb
    begin
        if (zero_b_reg)
            res_c_next = start_b_reg;
        else if ((&upper) || !(|upper))
            res_c_next = floored[COORD_BITS-1:0];
        else
            res_c_next = {sum_full[SB-1], {(COORD_BITS-1){~sum_full[SB-1]}}};
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            start_a_reg  <= start_value;
            end_a_reg    <= end_value;
            weight_a_reg <= weight;
            zero_a_reg   <= zero_steps;
            diff_a_reg   <= diff_a_next;
        end
        if (en[1])
        begin
            start_b_reg <= start_a_reg;
            end_b_reg   <= end_a_reg;
            zero_b_reg  <= zero_a_reg;
            prod_b_reg  <= prod_b_next;
        end
        if (en[2])
        begin
            res_c_reg <= res_c_next;
        end
    end

    assign result = res_c_reg;

endmodule

FILE: hw/rtl/bilinear_patch_interpolator_top.sv
// Top level of the bilinear patch interpolator: pipeline control and stage wiring.
//
// Usage notes.
// Input channel (patch_*): four corner components plus outer and inner step index
// and step count form one word, taken at a rising edge with patch_valid high and
// patch_stall low. Output channel (value_*): one saturated interpolated component
// per input word, taken when value_valid is high and value_stall low.
// Throughput: one word per cycle, sustained while value_stall stays low.
// Stage plan: four stages of a pipelined divider form floor(4096 / steps) for the
// outer and inner counts (four quotient bits per stage, the last takes the one
// left over), one stage forms both weights with a 13x13 multiply, then the top
// and bottom edges run side by side through a three-stage linear step, and the
// inner step takes another three.
// Each stage carries its own valid bit. A stage loads when it is empty or the
// stage after it moves, so a stalled output only holds back as many words as are
// queued behind it; empty stages keep filling and patch_stall rises only when
// every stage is occupied. Nothing is dropped or repeated across a stall.
// Reset clears every valid bit; the data registers are left as they are.
// A step count of zero passes the start value through unchanged.
module bilinear_patch_interpolator_top
    import bpi_pkg::*;
#(
    parameter int COORD_BITS = BPI_COORD_BITS
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         patch_valid,
    output logic                         patch_stall,
    input  logic signed [COORD_BITS-1:0] corner_zero,
    input  logic signed [COORD_BITS-1:0] corner_one,
    input  logic signed [COORD_BITS-1:0] corner_two,
    input  logic signed [COORD_BITS-1:0] corner_three,
    input  logic [IDX_BITS-1:0]          outer_index,
    input  logic [IDX_BITS-1:0]          inner_index,
    input  logic [IDX_BITS-1:0]          outer_steps,
    input  logic [IDX_BITS-1:0]          inner_steps,
    output logic                         value_valid,
    input  logic                         value_stall,
    output logic signed [COORD_BITS-1:0] interpolated_value
);

    localparam int W_STAGE  = RECIP_STAGES;
    localparam int O_FIRST  = W_STAGE + 1;
    localparam int I_FIRST  = O_FIRST + LERP_STAGES;

    // word alongside the divider
    typedef struct packed {
        logic signed [COORD_BITS-1:0] c0;
        logic signed [COORD_BITS-1:0] c1;
        logic signed [COORD_BITS-1:0] c2;
        logic signed [COORD_BITS-1:0] c3;
        logic [IDX_BITS-1:0]          oi;
        logic [IDX_BITS-1:0]          ii;
        logic                         oz;
        logic                         iz;
    } front_t;

    // word after the weight stage
    typedef struct packed {
        logic signed [COORD_BITS-1:0] c0;
        logic signed [COORD_BITS-1:0] c1;
        logic signed [COORD_BITS-1:0] c2;
        logic signed [COORD_BITS-1:0] c3;
        logic signed [W_BITS-1:0]     w_o;
        logic signed [W_BITS-1:0]     w_i;
        logic                         oz;
        logic                         iz;
    } mid_t;

    // inner-step controls alongside the outer step
    typedef struct packed {
        logic signed [W_BITS-1:0] w_i;
        logic                     iz;
    } side_t;

    logic [PIPE_STAGES-1:0] valid_reg;
    logic [PIPE_STAGES-1:0] valid_next;
    logic [PIPE_STAGES-1:0] en;

    front_t front_reg [RECIP_STAGES];
    front_t front_in;
    mid_t   mid_reg;
    mid_t   mid_next;
    side_t  side_reg [LERP_STAGES];

    logic [IDX_BITS-1:0]          quo_outer;
    logic [IDX_BITS-1:0]          quo_inner;
    logic [2*IDX_BITS-1:0]        prod_outer;
    logic [2*IDX_BITS-1:0]        prod_inner;
    logic signed [COORD_BITS-1:0] top_edge;
    logic signed [COORD_BITS-1:0] bottom_edge;

    // load enables, last stage first
    always_comb
    begin
        en[PIPE_STAGES-1] = !valid_reg[PIPE_STAGES-1] || !value_stall;
        for (int k = PIPE_STAGES - 2; k >= 0; k--)
            en[k] = !valid_reg[k] || en[k+1];
    end

    always_comb
    begin
        valid_next[0] = en[0] ? patch_valid : valid_reg[0];
        for (int k = 1; k < PIPE_STAGES; k++)
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign patch_stall = !en[0];
    assign value_valid = valid_reg[PIPE_STAGES-1];

    // divider stages
    bpi_recip u_recip_outer (
        .clk   (clk),
        .en    (en[RECIP_STAGES-1:0]),
        .steps (outer_steps),
        .quo   (quo_outer)
    );

    bpi_recip u_recip_inner (
        .clk   (clk),
        .en    (en[RECIP_STAGES-1:0]),
        .steps (inner_steps),
        .quo   (quo_inner)
    );

    always_comb
    begin
        front_in.c0 = corner_zero;
        front_in.c1 = corner_one;
        front_in.c2 = corner_two;
        front_in.c3 = corner_three;
        front_in.oi = outer_index;
        front_in.ii = inner_index;
        front_in.oz = (outer_steps == '0);
        front_in.iz = (inner_steps == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            front_reg[0] <= front_in;
        for (int k = 1; k < RECIP_STAGES; k++)
        begin
            if (en[k])
                front_reg[k] <= front_reg[k-1];
        end
    end

    // weight stage
    assign prod_outer = front_reg[RECIP_STAGES-1].oi * quo_outer;
    assign prod_inner = front_reg[RECIP_STAGES-1].ii * quo_inner;

    always_comb
    begin
        mid_next.c0  = front_reg[RECIP_STAGES-1].c0;
        mid_next.c1  = front_reg[RECIP_STAGES-1].c1;
        mid_next.c2  = front_reg[RECIP_STAGES-1].c2;
        mid_next.c3  = front_reg[RECIP_STAGES-1].c3;
        mid_next.oz  = front_reg[RECIP_STAGES-1].oz;
        mid_next.iz  = front_reg[RECIP_STAGES-1].iz;
        mid_next.w_o = $signed(W_BITS'(Q_ONE)) - $signed({1'b0, prod_outer});
        mid_next.w_i = $signed(W_BITS'(Q_ONE)) - $signed({1'b0, prod_inner});
    end

    always_ff @(posedge clk)
    begin
        if (en[W_STAGE])
            mid_reg <= mid_next;
    end

    // outer step, both edges
    bpi_lerp #(
        .COORD_BITS (COORD_BITS)
    ) u_lerp_top (
        .clk         (clk),
        .en          (en[O_FIRST+LERP_STAGES-1:O_FIRST]),
        .start_value (mid_reg.c0),
        .end_value   (mid_reg.c1),
        .weight      (mid_reg.w_o),
        .zero_steps  (mid_reg.oz),
        .result      (top_edge)
    );

    bpi_lerp #(
        .COORD_BITS (COORD_BITS)
    ) u_lerp_bottom (
        .clk         (clk),
        .en          (en[O_FIRST+LERP_STAGES-1:O_FIRST]),
        .start_value (mid_reg.c2),
        .end_value   (mid_reg.c3),
        .weight      (mid_reg.w_o),
        .zero_steps  (mid_reg.oz),
        .result      (bottom_edge)
    );

    always_ff @(posedge clk)
    begin
        if (en[O_FIRST])
        begin
            side_reg[0].w_i <= mid_reg.w_i;
            side_reg[0].iz  <= mid_reg.iz;
        end
        for (int k = 1; k < LERP_STAGES; k++)
        begin
            if (en[O_FIRST+k])
                side_reg[k] <= side_reg[k-1];
        end
    end

    // inner step, top edge to bottom edge
    bpi_lerp #(
        .COORD_BITS (COORD_BITS)
    ) u_lerp_inner (
        .clk         (clk),
        .en          (en[I_FIRST+LERP_STAGES-1:I_FIRST]),
        .start_value (top_edge),
        .end_value   (bottom_edge),
        .weight      (side_reg[LERP_STAGES-1].w_i),
        .zero_steps  (side_reg[LERP_STAGES-1].iz),
        .result      (interpolated_value)
    );

`ifndef SYNTHESIS
    // input held off only when the whole pipe is backed up
    assert property (@(posedge clk) disable iff (!rst_n)
        patch_stall |-> (value_valid && value_stall && (&valid_reg)))
    else $error("input stalled with room in the pipeline");

    // a word ready behind a free output stage lands there
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[PIPE_STAGES-2] && en[PIPE_STAGES-1]) |=> value_valid)
    else $error("word lost before the output stage");

    // weights never exceed one in Q12
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[W_STAGE] |-> ((mid_reg.w_o <= $signed(W_BITS'(Q_ONE)))
                             && (mid_reg.w_i <= $signed(W_BITS'(Q_ONE)))))
    else $error("weight above one");
`endif

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the bilinear patch interpolator top level.
`timescale 1ns / 1ps

module tb;
    import bpi_pkg::*;

    localparam int     N_DIRECTED = 20;
    localparam int     N_RANDOM   = 1850;
    localparam int     N_WORDS    = N_DIRECTED + N_RANDOM;
    localparam longint V_MAX      = (longint'(1) << (BPI_COORD_BITS - 1)) - 1;
    localparam longint V_MIN      = -V_MAX - 1;
    localparam int     DRAIN_MAX  = 5000;

    typedef logic signed [BPI_COORD_BITS-1:0] coord_t;
    typedef logic [IDX_BITS-1:0]              idx_t;

    // One input word; pinned = expected value typed into the table.
    typedef struct {
        coord_t c0;
        coord_t c1;
        coord_t c2;
        coord_t c3;
        idx_t   oi;
        idx_t   ii;
        idx_t   os;
        idx_t   is;
        bit     pinned;
        coord_t pinned_value;
    } patch_word_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   patch_valid;
    logic   patch_stall;
    coord_t corner_zero;
    coord_t corner_one;
    coord_t corner_two;
    coord_t corner_three;
    idx_t   outer_index;
    idx_t   inner_index;
    idx_t   outer_steps;
    idx_t   inner_steps;
    logic   value_valid;
    logic   value_stall;
    coord_t interpolated_value;

    patch_word_t directed_rows[$];
    coord_t      pending_values[$];
    int          n_sent  = 0;
    int          errors  = 0;

    bilinear_patch_interpolator_top u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .patch_valid        (patch_valid),
        .patch_stall        (patch_stall),
        .corner_zero        (corner_zero),
        .corner_one         (corner_one),
        .corner_two         (corner_two),
        .corner_three       (corner_three),
        .outer_index        (outer_index),
        .inner_index        (inner_index),
        .outer_steps        (outer_steps),
        .inner_steps        (inner_steps),
        .value_valid        (value_valid),
        .value_stall        (value_stall),
        .interpolated_value (interpolated_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    function automatic longint clamp_coord(input longint v);
        if (v > V_MAX)
        begin
            return V_MAX;
        end
        if (v < V_MIN)
        begin
            return V_MIN;
        end
        return v;
    endfunction

    // One Q12 linear step from start to finish. The weight can go negative when
    // the index runs past the step count, i.e. extrapolation beyond the end.
    // Steps above 4096 give a zero quotient, so the weight is a full 4096.
    function automatic longint lerp_q12(input longint start_v, input longint end_v,
                                        input longint idx, input longint steps);
        longint weight;
        longint diff;
        if (steps == 0)
        begin
            return clamp_coord(start_v);
        end
        weight = Q_ONE - idx * (Q_ONE / steps);
        diff   = clamp_coord(start_v - end_v);
        // arithmetic shift on a signed 64-bit value floors towards minus infinity
        return clamp_coord((end_v * Q_ONE + weight * diff) >>> Q_SHIFT);
    endfunction

    // Top and bottom edges along the outer axis, then between them on the inner.
    function automatic coord_t bilerp_patch(input patch_word_t w);
        longint top_v;
        longint bot_v;
        longint res;
        top_v = lerp_q12(longint'(w.c0), longint'(w.c1), longint'(w.oi), longint'(w.os));
        bot_v = lerp_q12(longint'(w.c2), longint'(w.c3), longint'(w.oi), longint'(w.os));
        res   = lerp_q12(top_v, bot_v, longint'(w.ii), longint'(w.is));
        return res[BPI_COORD_BITS-1:0];
    endfunction

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    function automatic void add_row(input int c0, input int c1, input int c2, input int c3,
                                    input int oi, input int ii, input int os, input int is,
                                    input bit pinned, input int pinned_value);
        patch_word_t w;
        w.c0           = coord_t'(c0);
        w.c1           = coord_t'(c1);
        w.c2           = coord_t'(c2);
        w.c3           = coord_t'(c3);
        w.oi           = idx_t'(oi);
        w.ii           = idx_t'(ii);
        w.os           = idx_t'(os);
        w.is           = idx_t'(is);
        w.pinned       = pinned;
        w.pinned_value = coord_t'(pinned_value);
        directed_rows.push_back(w);
    endfunction

    // No idling in a calm window mid-run, nor over the closing stretch.
    function automatic bit calm_phase(input int n);
        return (n >= 700 && n < 900) || (n >= N_WORDS - 250);
    endfunction

    function automatic coord_t rand_corner();
        case ($urandom_range(0, 11))
            0:       return V_MAX[BPI_COORD_BITS-1:0];
            1:       return V_MIN[BPI_COORD_BITS-1:0];
            2:       return '0;
            3:       return coord_t'(int'($urandom_range(0, 15)) - 8);
            default: return coord_t'($urandom);
        endcase
    endfunction

    // Mostly sensible index/step pairs; some zero counts and raw 13-bit noise.
    function automatic void rand_axis(output idx_t idx, output idx_t steps);
        int n;
        case ($urandom_range(0, 9))
            0:
            begin
                idx   = idx_t'($urandom);
                steps = idx_t'($urandom);
            end
            1:
            begin
                idx   = idx_t'($urandom);
                steps = '0;
            end
            2, 3:
            begin
                n     = 1 << $urandom_range(0, 12);
                steps = idx_t'(n);
                idx   = idx_t'($urandom_range(0, n));
            end
            4, 5, 6:
            begin
                n     = $urandom_range(1, 16);
                steps = idx_t'(n);
                idx   = idx_t'($urandom_range(0, n));
            end
            default:
            begin
                n     = $urandom_range(1, Q_ONE);
                steps = idx_t'(n);
                idx   = idx_t'($urandom_range(0, n));
            end
        endcase
    endfunction

    function automatic patch_word_t rand_word();
        patch_word_t w;
        w.c0     = rand_corner();
        w.c1     = rand_corner();
        w.c2     = rand_corner();
        w.c3     = rand_corner();
        rand_axis(w.oi, w.os);
        rand_axis(w.ii, w.is);
        w.pinned = 1'b0;
        w.pinned_value = '0;
        return w;
    endfunction

    // Offer one word, hold it until taken, then log the expected value.
    task automatic send_word(input patch_word_t w);
        int gap;
        gap = 0;
        if (!calm_phase(n_sent) && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
        end
        if (gap > 0)
        begin
            patch_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        corner_zero  <= w.c0;
        corner_one   <= w.c1;
        corner_two   <= w.c2;
        corner_three <= w.c3;
        outer_index  <= w.oi;
        inner_index  <= w.ii;
        outer_steps  <= w.os;
        inner_steps  <= w.is;
        patch_valid  <= 1'b1;
        @(posedge clk);
        while (patch_stall)
        begin
            @(posedge clk);
        end
        pending_values.push_back(w.pinned ? w.pinned_value : bilerp_patch(w));
        n_sent++;
    endtask

    task automatic flag_error(input string what, input coord_t want, input coord_t got);
        errors++;
        if (errors <= 10)
        begin
            $display("mismatch: %s expected %0d got %0d at %0t", what, want, got, $time);
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int waited;
        rst_n        = 1'b0;
        patch_valid  = 1'b0;
        corner_zero  = '0;
        corner_one   = '0;
        corner_two   = '0;
        corner_three = '0;
        outer_index  = '0;
        inner_index  = '0;
        outer_steps  = '0;
        inner_steps  = '0;

        //       c0      c1      c2      c3    oi    ii    os    is  pin  value
        add_row(     0,      0,      0,      0,    0,    0,    0,    0, 1,      0);
        add_row( 32767,      0,      0,      0,    0,    0,    0,    0, 1,  32767);
        add_row(-32768,      0,      0,      0,    0,    0,    0,    0, 1, -32768);
        // weight 4096 at index zero: start comes back
        add_row(   100,     50,      0,      0,    0,    0,    1,    0, 1,    100);
        // index equals count: end comes back
        add_row(   100,   -200,      0,      0,    1,    0,    1,    0, 1,   -200);
        // difference clamps to 32767, so end + diff = -1
        add_row( 32767, -32768,      0,      0,    0,    0,    1,    0, 1,     -1);
        // count above 4096: quotient zero, start comes back
        add_row(  1234,      0,      0,      0,    0,    0, 8191,    0, 1,   1234);
        // index far beyond count on the outer axis: saturates low
        add_row( 32767, -32768,      0,      0, 8191,    0,    1,    0, 1, -32768);
        // same on the inner axis
        add_row( 32767,      0, -32768,      0,    0, 8191,    0,    1, 1, -32768);
        add_row(     5,      0,     -7,      0,    0,    1,    0,    1, 1,     -7);
        add_row(-32768,  32767,  32767, -32768, 4096, 4096, 4096, 4096, 1, -32768);
        add_row(  1000,  -1000,   2000,  -2000,    2,    1,    4,    3, 0,      0);
        add_row( 32767,  32767, -32768, -32768, 4095,    1, 4096, 4096, 0,      0);
        // floor on small negative sums
        add_row(    -1,      1,     -1,      1,    1,    1,    3,    3, 0,      0);
        add_row( 12345, -23456, -31000,  30000, 2048, 2048, 4096, 4096, 0,      0);
        add_row(   300,   -301,     -5,      9, 4096,    0, 4096,    0, 0,      0);
        add_row( 20000, -20000, -20000,  20000, 4097,    5, 4096,    3, 0,      0);
        add_row(   111,    222,    333,    444,    3,    2, 4097, 8191, 0,      0);
        add_row( 21845, -21846, -21846,  21845, 'hAAA,'h1555,'h1555, 'hAAA, 0,  0);
        add_row(-32768, -32768,  32767,  32767,    1,    2,    3,    5, 0,      0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[k])
        begin
            send_word(directed_rows[k]);
        end
        repeat (N_RANDOM)
        begin
            send_word(rand_word());
        end
        patch_valid <= 1'b0;

        waited = 0;
        while (pending_values.size() != 0 && waited < DRAIN_MAX)
        begin
            @(posedge clk);
            waited++;
        end
        if (pending_values.size() != 0)
        begin
            flag_error("value never came", pending_values[0], 'x);
            errors += pending_values.size() - 1;
        end
        // catch any stray word after the last expected one
        repeat (2 * PIPE_STAGES + 4) @(posedge clk);

        if (errors == 0)
        begin
            $display("tb: clean");
        end
        else
        begin
            $display("tb: errors");
        end
        $finish;
    end

    // ---------------------------------------------------------------
    // Output side: random stall bursts, plus one long hold-off so the
    // pipe fills and pushes back on the input.
    // ---------------------------------------------------------------
    initial
    begin
        int  stall_left;
        bit  held_off;
        stall_left  = 0;
        held_off    = 1'b0;
        value_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
            end
            else if (!held_off && n_sent >= 300)
            begin
                held_off   = 1'b1;
                stall_left = 80;
            end
            else if (!calm_phase(n_sent) && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(1, 7);
            end
            value_stall <= (stall_left > 0);
        end
    end

    // Scoreboard: every word taken from the block against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && value_valid && !value_stall)
        begin
            if (pending_values.size() == 0)
            begin
                flag_error("word with nothing pending", 'x, interpolated_value);
            end
            else
            begin
                if (interpolated_value !== pending_values[0])
                begin
                    flag_error("interpolated_value", pending_values[0], interpolated_value);
                end
                void'(pending_values.pop_front());
            end
        end
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #3_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
